/* hw/rtl/bmorph_pkg.sv */
`default_nettype none

package bmorph_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DSHAPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESHAPE = 3'd4;

    localparam logic OP_DILATE = 1'b0;
    localparam logic OP_ERODE  = 1'b1;

    localparam logic SHAPE_IS_CROSS  = 1'b0;

    // bit k is window entry k, top left first
    localparam logic [8:0] SHAPE_CROSS  = 9'b010_111_010;
    localparam logic [8:0] SHAPE_SQUARE = 9'b111_111_111;

    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } bmorph_pos_t;

    typedef struct packed {
        logic   last;
        pixel_t pixel;
    } bmorph_res_t;

endpackage

`default_nettype wire

/* hw/rtl/bmorph_ram.sv */
`default_nettype none

module bmorph_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]                 rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/bmorph_win.sv */
`default_nettype none

module bmorph_win
    import bmorph_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    input  wire pixel_t      top,
    input  wire pixel_t      mid,
    input  wire pixel_t      pix,
    input  wire bmorph_pos_t pos,
    input  wire logic        op,
    input  wire logic        dshape,
    input  wire logic        eshape,
    output logic             res_valid,
    output bmorph_res_t      res
);

    pixel_t     win_reg  [9];
    pixel_t     win_next [9];
    logic [8:0] shape;
    logic [8:0] use_k;
    logic       erode;
    logic       hit;

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = pix;
    end

    always_comb
    begin
        int   r;
        int   c;
        int   k;
        logic fg;
        erode = (op == OP_ERODE);
        if (erode)
        begin
            shape = (eshape == SHAPE_IS_CROSS) ? SHAPE_CROSS : SHAPE_SQUARE;
        end
        else
        begin
            shape = (dshape == SHAPE_IS_CROSS) ? SHAPE_CROSS : SHAPE_SQUARE;
        end
        hit   = 1'b0;
        use_k = '0;
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                k = r * 3 + c;
                use_k[k] = shape[k]
                         && !(r == 0 && !pos.top_ok)
                         && !(r == 2 && !pos.bot_ok)
                         && !(c == 0 && !pos.left_ok)
                         && !(c == 2 && !pos.right_ok);
                fg  = (win_next[k] != PIX_ZERO);
                hit = hit | (use_k[k] & (erode ? !fg : fg));
            end
        end
        if (hit)
        begin
            res.pixel = erode ? PIX_ZERO : PIX_FULL;
        end
        else
        begin
            res.pixel = win_next[4];
        end
        res.last  = pos.last;
        res_valid = valid && pos.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= PIX_ZERO;
            end
        end
        else if (valid)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/binary_morphology_3x3.sv */
`default_nettype none
// one item per clock while the queue has room; both line store rams are read on accept
// and written the cycle after, with a bypass for a column read and written back to back
// a result enters the 3-entry output queue at the edge after its item is accepted, and
// the result of a pixel is produced by the item arriving image_width + 1 items later
// reset clears counters, window and queue and loads register defaults; line stores keep
// their contents and get no clearing pass, so the block is ready right after reset
module binary_morphology_3x3
    import bmorph_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // pixel_in
    input  wire logic                  s_axis_tuser,   // flush
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // pixel_out
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WXW   = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
    localparam int HXW   = (RW + 1 > HEIGHT_REG_W) ? RW + 1 : HEIGHT_REG_W;
    localparam int LW    = CW + 2;
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
    localparam int QD    = 3;
    localparam int QAW   = $clog2(QD);

    // configuration
    logic [CW:0]    width_reg;
    logic [RW:0]    height_reg;
    logic           op_reg;
    logic           dshape_reg;
    logic           eshape_reg;
    logic [WXW-1:0] w_wr;
    logic [CW:0]    w_clamp;
    logic [HXW-1:0] h_wr;
    logic [RW:0]    h_clamp;

    // positions and counts
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [LW-1:0]  lead_reg, lead_next;
    logic [LW-1:0]  pending_reg, pending_next;
    logic           draining_reg;

    // stage 0
    logic           accept;
    logic           fl;
    pixel_t         pix0;
    logic           restart;
    logic [CW-1:0]  ic;
    logic [RW-1:0]  ir;
    logic [CW-1:0]  oc;
    logic [RW-1:0]  orow;
    logic [LW-1:0]  ld;
    logic [LW-1:0]  pd;
    logic [LW-1:0]  pd_inc;
    logic [LW-1:0]  w_plus2;
    logic           col_last;
    logic           row_last;
    bmorph_pos_t    pos0;

    // stage 1
    logic           v1_reg;
    logic [CW-1:0]  col1_reg;
    pixel_t         pix1_reg;
    bmorph_pos_t    pos1_reg;
    logic           fwd_reg;
    pixel_t         fwd_top_reg;
    pixel_t         fwd_mid_reg;
    pixel_t         a_rd;
    pixel_t         b_rd;
    pixel_t         top1;
    pixel_t         mid1;
    logic           push;
    bmorph_res_t    res1;

    // output queue
    bmorph_res_t    q_mem [QD];
    logic [QAW-1:0] head_reg;
    logic [QAW-1:0] tail_reg;
    logic [QAW:0]   cnt_reg;
    logic           pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        w_wr = WXW'(cfg_data[WIDTH_REG_W-1:0]);
        if (w_wr == '0)
        begin
            w_clamp = (CW + 1)'(1);
        end
        else if (w_wr > WXW'(MAX_WIDTH))
        begin
            w_clamp = (CW + 1)'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = w_wr[CW:0];
        end
        h_wr = HXW'(cfg_data[HEIGHT_REG_W-1:0]);
        if (h_wr == '0)
        begin
            h_clamp = (RW + 1)'(1);
        end
        else if (h_wr > HXW'(MAX_HEIGHT))
        begin
            h_clamp = (RW + 1)'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = h_wr[RW:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= (CW + 1)'(W_RST);
            height_reg <= (RW + 1)'(H_RST);
            op_reg     <= OP_DILATE;
            dshape_reg <= SHAPE_IS_CROSS;
            eshape_reg <= SHAPE_IS_CROSS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= w_clamp;
                REG_HEIGHT: height_reg <= h_clamp;
                REG_OP:     op_reg     <= cfg_data[0];
                REG_DSHAPE: dshape_reg <= cfg_data[0];
                REG_ESHAPE: eshape_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // stage 0: positions, result scheduling, line store read
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign fl      = s_axis_tuser;
    assign pix0    = fl ? PIX_ZERO : s_axis_tdata;
    assign restart = !fl && draining_reg;
    assign w_plus2 = LW'(width_reg) + LW'(2);

    always_comb
    begin
        ic   = restart ? '0 : in_col_reg;
        ir   = restart ? '0 : in_row_reg;
        oc   = restart ? '0 : out_col_reg;
        orow = restart ? '0 : out_row_reg;
        ld   = restart ? '0 : lead_reg;
        pd   = restart ? '0 : pending_reg;

        if (({1'b0, ic} + (CW + 1)'(1)) >= width_reg)
        begin
            in_col_next = '0;
            in_row_next = (({1'b0, ir} + (RW + 1)'(1)) >= height_reg) ? '0 : ir + RW'(1);
        end
        else
        begin
            in_col_next = ic + CW'(1);
            in_row_next = ir;
        end

        lead_next = (ld < w_plus2) ? ld + LW'(1) : ld;
        pd_inc    = fl ? pd : pd + LW'(1);

        col_last = ({1'b0, oc} + (CW + 1)'(1)) >= width_reg;
        row_last = ({1'b0, orow} + (RW + 1)'(1)) >= height_reg;

        pos0.emit     = (lead_next >= w_plus2) && (pd_inc != '0);
        pos0.last     = row_last && col_last;
        pos0.top_ok   = (orow != '0);
        pos0.bot_ok   = !row_last;
        pos0.left_ok  = (oc != '0);
        pos0.right_ok = !col_last;

        if (pos0.emit)
        begin
            pending_next = pd_inc - LW'(1);
            if (col_last)
            begin
                out_col_next = '0;
                out_row_next = row_last ? '0 : orow + RW'(1);
            end
            else
            begin
                out_col_next = oc + CW'(1);
                out_row_next = orow;
            end
        end
        else
        begin
            pending_next = pd_inc;
            out_col_next = oc;
            out_row_next = orow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            lead_reg     <= '0;
            pending_reg  <= '0;
            draining_reg <= 1'b0;
            v1_reg       <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            if (accept)
            begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                lead_reg     <= lead_next;
                pending_reg  <= pending_next;
                draining_reg <= fl;
            end
        end
    end

    // stage 1 payload; bypass when the column read now is written back this cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col1_reg    <= ic;
            pix1_reg    <= pix0;
            pos1_reg    <= pos0;
            fwd_reg     <= v1_reg && (col1_reg == ic);
            fwd_top_reg <= mid1;
            fwd_mid_reg <= pix1_reg;
        end
    end

    assign top1 = fwd_reg ? fwd_top_reg : b_rd;
    assign mid1 = fwd_reg ? fwd_mid_reg : a_rd;

    bmorph_ram #(
        .DEPTH (MAX_WIDTH),
        .DW    (PIX_W)
    ) u_line_a (
        .clk     (clk),
        .wr_en   (v1_reg),
        .wr_addr (col1_reg),
        .wr_data (pix1_reg),
        .rd_en   (accept),
        .rd_addr (ic),
        .rd_data (a_rd)
    );

    bmorph_ram #(
        .DEPTH (MAX_WIDTH),
        .DW    (PIX_W)
    ) u_line_b (
        .clk     (clk),
        .wr_en   (v1_reg),
        .wr_addr (col1_reg),
        .wr_data (mid1),
        .rd_en   (accept),
        .rd_addr (ic),
        .rd_data (b_rd)
    );

    bmorph_win u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (v1_reg),
        .top       (top1),
        .mid       (mid1),
        .pix       (pix1_reg),
        .pos       (pos1_reg),
        .op        (op_reg),
        .dshape    (dshape_reg),
        .eshape    (eshape_reg),
        .res_valid (push),
        .res       (res1)
    );

    // output queue
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = q_mem[head_reg].pixel;
    assign m_axis_tlast  = q_mem[head_reg].last;
    assign s_axis_tready = ((QAW + 1)'(cnt_reg) + (QAW + 1)'(push)) < (QAW + 1)'(QD);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail_reg] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == QAW'(QD - 1)) ? '0 : tail_reg + QAW'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == QAW'(QD - 1)) ? '0 : head_reg + QAW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (QAW + 1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (QAW + 1)'(1);
            end
        end
    end

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (cnt_reg != (QAW + 1)'(QD)))
        else $error("output queue overflow");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_axis_tuser && draining_reg) |=>
        (out_col_reg == '0 && out_row_reg == '0 && pending_reg == LW'(1)))
        else $error("pixel after flush did not restart the stream");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= lead_reg)
        else $error("more pending pixels than items seen");

endmodule

`default_nettype wire
